// File: design/cyptm_pkg.sv
package cyptm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int FILTER_SHIFT = 2;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 23;
  localparam int THR_W      = 31;
  localparam int SUM_W      = 40;
  localparam int THRUST_W   = 17;
  localparam int CFG_ADDR_W = 3;

  // shared multiplier: zero-extended gain times a 33-bit signed operand
  localparam int OPB_W  = DATA_W + 1;
  localparam int PROD_W = GAIN_W + 1 + OPB_W;

  localparam int LPF_W = DATA_W + FILTER_SHIFT + 2;

  localparam logic [THRUST_W-1:0] THRUST_FULL = THRUST_W'(1 << FRAC_BITS);

  // register indexes on the write port
  localparam logic [CFG_ADDR_W-1:0] REG_HEADING_SETPOINT     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTER_PROP_GAIN      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTER_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_PROP_GAIN      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_DERIV_GAIN     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_INTEGRAL_GAIN  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SEPARATION_THRESHOLD = 3'd6;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] S40_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] S40_MIN = -64'sh0000_0080_0000_0000;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > S32_MAX) c = S32_MAX;
    if (v < S32_MIN) c = S32_MIN;
    return c[DATA_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > S40_MAX) c = S40_MAX;
    if (v < S40_MIN) c = S40_MIN;
    return c[SUM_W-1:0];
  endfunction

  // filt = (d + (2^S - 1) * prev) >>> S, saturated
  function automatic logic signed [DATA_W-1:0] lpf(input logic signed [DATA_W-1:0] d,
                                                  input logic signed [DATA_W-1:0] prev);
    logic signed [LPF_W-1:0] s;
    s = LPF_W'(d) + (LPF_W'(prev) <<< FILTER_SHIFT) - LPF_W'(prev);
    return sat32(64'(s >>> FILTER_SHIFT));
  endfunction

endpackage

// File: design/cascade_yaw_pid_thruster_mix_core.sv
// Channel | Direction | Handshake        | Payload
// in_     | input     | tvalid / tready  | tdata: heading, yaw_rate
// out_    | output    | tvalid / tready  | tdata: thrust_a..d, inner_output
// cfg_    | input     | cfg_we only      | cfg_addr, cfg_wdata
//
// Each request passes through the accept cycle and eight sequencer steps, since the
// single 24x33 multiplier carries six products (the 40-bit integral as two).
// in_tready is high only in idle; the result waits in the output register, and the
// final step holds while that register is still full and not taken.
// rst_n is synchronous: gains and threshold return to defaults, loop state to zero.
module cascade_yaw_pid_thruster_mix_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,   // heading[31:0], yaw_rate[63:32]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // thrust_a[16:0], thrust_b[33:17], thrust_c[50:34], thrust_d[67:51],
  // inner_output[99:68], zero[103:100]
  output logic [103:0]                        out_tdata,
  input  logic                                cfg_we,
  input  logic [cyptm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [31:0]                         cfg_wdata
);

  localparam int F  = cyptm_pkg::FRAC_BITS;
  localparam int DW = cyptm_pkg::DATA_W;
  localparam int GW = cyptm_pkg::GAIN_W;
  localparam int SW = cyptm_pkg::SUM_W;
  localparam int TW = cyptm_pkg::THRUST_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_OD   = 9'b000000010,
    S_OP   = 9'b000000100,
    S_ID   = 9'b000001000,
    S_EIN  = 9'b000010000,
    S_ILO  = 9'b000100000,
    S_IP   = 9'b001000000,
    S_SUM  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [DW-1:0]              setpoint_r;
  logic [GW-1:0]                     opg_r, odg_r, ipg_r, idg_r, iig_r;
  logic [cyptm_pkg::THR_W-1:0]       thr_r;

  // loop state
  logic signed [DW-1:0] ope_r, opd_r, ofd_r, ipe_r, ipd_r, ifd_r;
  logic signed [SW-1:0] ies_r;

  // working registers
  logic signed [DW-1:0]                 e_out_r, yaw_r, ref_r, e_in_r, int_r, u_r;
  logic signed [cyptm_pkg::PROD_W-1:0]  hi_r;
  logic                                 inside_r;

  // output register
  logic              out_valid_r;
  logic [TW-1:0]     thr_a_r, thr_b_r, thr_c_r, thr_d_r;
  logic signed [DW-1:0] inner_out_r;

  // shared multiplier
  logic [GW-1:0]                          mul_a;
  logic signed [cyptm_pkg::OPB_W-1:0]     mul_b;
  logic signed [cyptm_pkg::PROD_W-1:0]    prod_r;
  logic signed [DW-1:0]                   prod_sat;

  logic signed [DW-1:0] in_heading, in_yaw;
  logic                 in_acc, out_load;
  logic signed [DW:0]   thr_s, e_in_x, mag;
  logic [DW-1:0]        half;
  logic [TW-1:0]        drive;

  assign in_heading = $signed(in_tdata[31:0]);
  assign in_yaw     = $signed(in_tdata[63:32]);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, inner_out_r, thr_d_r, thr_c_r, thr_b_r, thr_a_r};

  cyptm_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_OD: begin
        mul_a = odg_r;
        mul_b = cyptm_pkg::OPB_W'(opd_r);
      end
      S_OP: begin
        mul_a = opg_r;
        mul_b = cyptm_pkg::OPB_W'(e_out_r);
      end
      S_ID: begin
        mul_a = idg_r;
        mul_b = cyptm_pkg::OPB_W'(ipd_r);
      end
      S_EIN: begin
        // integral upper part, signed
        mul_a = iig_r;
        mul_b = cyptm_pkg::OPB_W'($signed(ies_r[SW-1:F]));
      end
      S_ILO: begin
        // integral lower part, unsigned
        mul_a = iig_r;
        mul_b = cyptm_pkg::OPB_W'($signed({1'b0, ies_r[F-1:0]}));
      end
      S_IP: begin
        mul_a = ipg_r;
        mul_b = cyptm_pkg::OPB_W'(e_in_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_sat = cyptm_pkg::sat32(64'(prod_r >>> F));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_OD;
      S_OD:    state_nxt = S_OP;
      S_OP:    state_nxt = S_ID;
      S_ID:    state_nxt = S_EIN;
      S_EIN:   state_nxt = S_ILO;
      S_ILO:   state_nxt = S_IP;
      S_IP:    state_nxt = S_SUM;
      S_SUM:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // thruster mix from the saturated output
  assign thr_s  = $signed({2'b00, thr_r});
  assign e_in_x = (DW + 1)'(e_in_r);
  assign mag    = u_r[DW-1] ? -((DW + 1)'(u_r)) : (DW + 1)'(u_r);
  assign half   = mag[DW:1];
  assign drive  = (half > DW'(cyptm_pkg::THRUST_FULL)) ? cyptm_pkg::THRUST_FULL : half[TW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      opg_r      <= GW'(32768);
      odg_r      <= GW'(3277);
      ipg_r      <= GW'(39322);
      idg_r      <= GW'(23593);
      iig_r      <= GW'(197);
      thr_r      <= cyptm_pkg::THR_W'(1081344);
    end else if (cfg_we) begin
      case (cfg_addr)
        cyptm_pkg::REG_HEADING_SETPOINT:     setpoint_r <= $signed(cfg_wdata);
        cyptm_pkg::REG_OUTER_PROP_GAIN:      opg_r <= cfg_wdata[GW-1:0];
        cyptm_pkg::REG_OUTER_DERIV_GAIN:     odg_r <= cfg_wdata[GW-1:0];
        cyptm_pkg::REG_INNER_PROP_GAIN:      ipg_r <= cfg_wdata[GW-1:0];
        cyptm_pkg::REG_INNER_DERIV_GAIN:     idg_r <= cfg_wdata[GW-1:0];
        cyptm_pkg::REG_INNER_INTEGRAL_GAIN:  iig_r <= cfg_wdata[GW-1:0];
        cyptm_pkg::REG_SEPARATION_THRESHOLD: thr_r <= cfg_wdata[cyptm_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ope_r <= '0;
      opd_r <= '0;
      ofd_r <= '0;
      ipe_r <= '0;
      ipd_r <= '0;
      ifd_r <= '0;
      ies_r <= '0;
    end else begin
      case (state_r)
        S_OP: begin
          ofd_r <= cyptm_pkg::lpf(prod_sat, ofd_r);
          opd_r <= cyptm_pkg::sat32(64'(e_out_r) - 64'(ope_r));
          ope_r <= e_out_r;
        end
        S_EIN: begin
          ifd_r <= cyptm_pkg::lpf(prod_sat, ifd_r);
        end
        S_ILO: begin
          ipd_r <= cyptm_pkg::sat32(64'(e_in_r) - 64'(ipe_r));
          ipe_r <= e_in_r;
        end
        S_IP: begin
          // frozen outside the separation band
          if (inside_r) ies_r <= cyptm_pkg::sat40(64'(ies_r) + 64'(e_in_r));
        end
        default: ;
      endcase
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_out_r <= cyptm_pkg::sat32(64'(setpoint_r) - 64'(in_heading));
      yaw_r   <= in_yaw;
    end
    case (state_r)
      S_ID:  ref_r <= cyptm_pkg::sat32(64'(prod_sat) + 64'(ofd_r));
      S_EIN: e_in_r <= cyptm_pkg::sat32(64'(ref_r) - 64'(yaw_r));
      S_ILO: begin
        hi_r     <= prod_r;
        inside_r <= (e_in_x < thr_s) && (e_in_x > -thr_s);
      end
      // gain*hi + floor(gain*lo / 2^F)
      S_IP:  int_r <= cyptm_pkg::sat32(64'(hi_r) + 64'(prod_r >>> F));
      S_SUM: u_r <= cyptm_pkg::sat32(64'(prod_sat) + 64'(ifd_r)
                                     + (inside_r ? 64'(int_r) : 64'sd0));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inner_out_r <= u_r;
      thr_a_r     <= u_r[DW-1] ? '0 : drive;
      thr_d_r     <= u_r[DW-1] ? '0 : drive;
      thr_b_r     <= u_r[DW-1] ? drive : '0;
      thr_c_r     <= u_r[DW-1] ? drive : '0;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_OD))
    else $error("sequencer did not start after request");

  a_integral_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IP) && !inside_r) |=> $stable(ies_r))
    else $error("integral moved outside separation band");

  a_thrust_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((thr_a_r == thr_d_r) && (thr_b_r == thr_c_r)
                     && ((thr_a_r == '0) || (thr_b_r == '0))))
    else $error("thruster pairs inconsistent");

  a_thrust_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((thr_a_r <= cyptm_pkg::THRUST_FULL)
                     && (thr_b_r <= cyptm_pkg::THRUST_FULL)))
    else $error("thrust above full scale");

  a_thrust_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && inner_out_r[DW-1]) |-> (thr_a_r == '0))
    else $error("negative output drove forward thrusters");

endmodule

// File: design/cyptm_mul.sv
module cyptm_mul (
  input  logic                                      clk,
  input  logic        [cyptm_pkg::GAIN_W-1:0]       mul_a,
  input  logic signed [cyptm_pkg::OPB_W-1:0]        mul_b,
  output logic signed [cyptm_pkg::PROD_W-1:0]       prod_r
);

  logic signed [cyptm_pkg::GAIN_W:0] a_s;

  assign a_s = $signed({1'b0, mul_a});

  // both operands widened to the full product width so no bits drop
  always_ff @(posedge clk) begin
    prod_r <= cyptm_pkg::PROD_W'(a_s) * cyptm_pkg::PROD_W'(mul_b);
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam longint LIM32_HI    = 64'sd2147483647;
  localparam longint LIM32_LO    = -64'sd2147483648;
  localparam longint LIM40_HI    = 64'sd549755813887;
  localparam longint LIM40_LO    = -64'sd549755813888;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     HOLD_CYCLES = 300;
  localparam int     SETTLE      = 12;

  localparam logic [cyptm_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [3:0][cyptm_pkg::THRUST_W-1:0] thrust;
    logic [31:0]                         effort;
  } mix_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata   = '0;   // heading[31:0], yaw_rate[63:32]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // thrust_a[16:0], thrust_b[33:17], thrust_c[50:34], thrust_d[67:51],
  // inner_output[99:68], zero[103:100]
  logic [103:0] out_tdata;
  logic         cfg_we     = 1'b0;
  logic [cyptm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0]  cfg_wdata  = '0;

  int  src_idle_pct = 0;
  int  stall_pct    = 0;
  bit  sink_hold_on = 1'b0;
  int  err_cnt      = 0;
  int  cycle_cnt    = 0;
  event hold_kick;

  mix_result_t thrust_q[$];

  // controller shadow: registers
  longint setpoint, kp_out, kd_out, kp_in, kd_in, ki_in, sep_thr;
  // controller shadow: loop state
  longint o_prev_err, o_prev_diff, o_filt;
  longint i_prev_err, i_prev_diff, i_filt, i_sum;

  cascade_yaw_pid_thruster_mix_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // controller shadow
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(input longint v);
    if (v > LIM32_HI) return LIM32_HI;
    if (v < LIM32_LO) return LIM32_LO;
    return v;
  endfunction

  function automatic longint clamp40(input longint v);
    if (v > LIM40_HI) return LIM40_HI;
    if (v < LIM40_LO) return LIM40_LO;
    return v;
  endfunction

  // gain is at most 23 bits and v at most 40, so the product fits in 64
  function automatic longint scale_gain(input longint g, input longint v);
    return (g * v) >>> cyptm_pkg::FRAC_BITS;
  endfunction

  function automatic longint smooth(input longint d, input longint prev);
    longint w;
    w = (longint'(1) << cyptm_pkg::FILTER_SHIFT) - 1;
    return clamp32((d + w * prev) >>> cyptm_pkg::FILTER_SHIFT);
  endfunction

  function automatic void model_reset();
    setpoint = 0;
    kp_out   = 32768;
    kd_out   = 3277;
    kp_in    = 39322;
    kd_in    = 23593;
    ki_in    = 197;
    sep_thr  = 1081344;
    o_prev_err = 0; o_prev_diff = 0; o_filt = 0;
    i_prev_err = 0; i_prev_diff = 0; i_filt = 0; i_sum = 0;
  endfunction

  function automatic void model_config(input logic [cyptm_pkg::CFG_ADDR_W-1:0] addr,
                                       input logic [31:0] data);
    case (addr)
      cyptm_pkg::REG_HEADING_SETPOINT:     setpoint = longint'($signed(data));
      cyptm_pkg::REG_OUTER_PROP_GAIN:      kp_out   = longint'(data[22:0]);
      cyptm_pkg::REG_OUTER_DERIV_GAIN:     kd_out   = longint'(data[22:0]);
      cyptm_pkg::REG_INNER_PROP_GAIN:      kp_in    = longint'(data[22:0]);
      cyptm_pkg::REG_INNER_DERIV_GAIN:     kd_in    = longint'(data[22:0]);
      cyptm_pkg::REG_INNER_INTEGRAL_GAIN:  ki_in    = longint'(data[22:0]);
      cyptm_pkg::REG_SEPARATION_THRESHOLD: sep_thr  = longint'(data[30:0]);
      default: ;
    endcase
  endfunction

  // rate reference of the outer loop; state only moves when commit is set
  function automatic longint outer_ref(input logic [31:0] hdg, input bit commit);
    longint e, d, f, r;
    e = clamp32(setpoint - longint'($signed(hdg)));
    d = clamp32(scale_gain(kd_out, o_prev_diff));
    f = smooth(d, o_filt);
    r = clamp32(clamp32(scale_gain(kp_out, e)) + f);
    if (commit) begin
      o_filt      = f;
      o_prev_diff = clamp32(e - o_prev_err);
      o_prev_err  = e;
    end
    return r;
  endfunction

  function automatic mix_result_t mix_predict(input logic [31:0] hdg, input logic [31:0] rate);
    mix_result_t r;
    longint e_in, d, u, mag, drv, full;
    bit in_band;
    e_in   = clamp32(outer_ref(hdg, 1'b1) - longint'($signed(rate)));
    d      = clamp32(scale_gain(kd_in, i_prev_diff));
    i_filt = smooth(d, i_filt);
    in_band = (e_in < sep_thr) && (e_in > -sep_thr);
    u = clamp32(scale_gain(kp_in, e_in)) + i_filt;
    if (in_band) u = u + clamp32(scale_gain(ki_in, i_sum));
    u = clamp32(u);
    i_prev_diff = clamp32(e_in - i_prev_err);
    if (in_band) i_sum = clamp40(i_sum + e_in);
    i_prev_err = e_in;

    full = longint'(1) << cyptm_pkg::FRAC_BITS;
    mag  = (u < 0) ? -u : u;
    drv  = mag >>> 1;
    if (drv > full) drv = full;
    r.thrust = '0;
    r.effort = u[31:0];
    if (u >= 0) begin
      r.thrust[0] = drv[16:0];
      r.thrust[3] = drv[16:0];
    end else begin
      r.thrust[1] = drv[16:0];
      r.thrust[2] = drv[16:0];
    end
    return r;
  endfunction

  // yaw rate that puts the inner error at err on the next request
  function automatic logic [31:0] rate_for_error(input logic [31:0] hdg, input longint err);
    longint v;
    v = clamp32(outer_ref(hdg, 1'b0) - err);
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || sink_hold_on) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : sink_hold
    forever begin
      @(hold_kick);
      sink_hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_hold_on = 1'b0;
    end
  end

  always @(posedge clk) begin
    mix_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      for (int i = 0; i < 4; i++) got.thrust[i] = out_tdata[i*17 +: 17];
      got.effort = out_tdata[99:68];
      if (thrust_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none expected: expected none, got %h", $time, got);
      end else begin
        want = thrust_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.thrust[i] !== want.thrust[i]) begin
            err_cnt++;
            $display("%0t: thrust %0d: expected %h, got %h",
                     $time, i, want.thrust[i], got.thrust[i]);
          end
        end
        if (got.effort !== want.effort) begin
          err_cnt++;
          $display("%0t: inner_output: expected %h, got %h", $time, want.effort, got.effort);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side and register writes
  // ---------------------------------------------------------------------------
  task automatic push_sample(input logic [31:0] hdg, input logic [31:0] rate);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rate, hdg};
    do @(posedge clk); while (!in_tready);
    thrust_q.push_back(mix_predict(hdg, rate));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (thrust_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [cyptm_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    model_config(addr, data);
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] sp, input logic [31:0] kpo,
                              input logic [31:0] kdo, input logic [31:0] kpi,
                              input logic [31:0] kdi, input logic [31:0] kii,
                              input logic [31:0] thr);
    wait_for_results();
    cfg_write(cyptm_pkg::REG_HEADING_SETPOINT, sp);
    cfg_write(cyptm_pkg::REG_OUTER_PROP_GAIN, kpo);
    cfg_write(cyptm_pkg::REG_OUTER_DERIV_GAIN, kdo);
    cfg_write(cyptm_pkg::REG_INNER_PROP_GAIN, kpi);
    cfg_write(cyptm_pkg::REG_INNER_DERIV_GAIN, kdi);
    cfg_write(cyptm_pkg::REG_INNER_INTEGRAL_GAIN, kii);
    cfg_write(cyptm_pkg::REG_SEPARATION_THRESHOLD, thr);
    cfg_release();
  endtask

  // mostly modest gains; junk above bit 22 checks the register width
  function automatic logic [31:0] rand_gain();
    logic [22:0] g;
    case ($urandom_range(9))
      0:       g = 23'h7F_FFFF;
      1, 2:    g = 23'($urandom_range(0, 4194304));
      default: g = 23'($urandom_range(0, 1 << 18));
    endcase
    return {9'($urandom), g};
  endfunction

  function automatic void gen_random_item(output logic [31:0] hdg, output logic [31:0] rate);
    longint k;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      // close to setpoint, slow turn
      hdg  = setpoint[31:0] + 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      rate = 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    end else if (sel < 60) begin
      hdg = setpoint[31:0] + 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      case ($urandom_range(4))
        0:       k = sep_thr;
        1:       k = sep_thr - 1;
        2:       k = -sep_thr;
        3:       k = 1 - sep_thr;
        default: k = 0;
      endcase
      rate = rate_for_error(hdg, k);
    end else if (sel < 80) begin
      hdg  = $urandom;
      rate = $urandom;
    end else begin
      hdg  = 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      rate = 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    src_idle_pct = 0;
    stall_pct    = 0;
    push_sample(32'h0000_0000, 32'h0000_0000);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(32'hFFFF_FFFF, 32'h0000_0001);
    // separation band edges: on the edge is outside, one step in is inside
    push_sample(32'h0, rate_for_error(32'h0, sep_thr));
    push_sample(32'h0, rate_for_error(32'h0, sep_thr - 1));
    push_sample(32'h0, rate_for_error(32'h0, -sep_thr));
    push_sample(32'h0, rate_for_error(32'h0, 1 - sep_thr));
    push_sample(32'h0000_0100, 32'h0000_2000);
    push_sample(32'hFFFF_FF00, 32'hFFFF_E000);
    push_sample(32'h0001_0000, 32'h0000_0000);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    longint cap_err[5];
    cap_err = '{64'sh2_0000, 64'sh2_0001, -64'sh2_0000, -64'sh2_0003, 64'sd1};
    src_idle_pct = 0;
    stall_pct    = 0;
    program_regs(32'h7FFF_FFFF, '1, '1, '1, '1, '1, '1);
    cfg_write(REG_UNUSED, $urandom);
    cfg_release();
    push_sample(32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(32'h0000_0000, 32'h0000_0000);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(32'h1234_5678, rate_for_error(32'h1234_5678, sep_thr - 1));

    // everything off, band closed
    program_regs(32'h8000_0000, '0, '0, '0, '0, '0, '0);
    push_sample(32'h7FFF_FFFF, 32'h0000_0000);
    push_sample(32'h0000_0000, 32'h0000_0000);
    push_sample(32'h8000_0000, 32'h8000_0000);

    // unity inner gain only: walk the drive across the full-scale cap
    program_regs('0, '0, '0, 32'h0001_0000, '0, '0, '0);
    foreach (cap_err[i]) push_sample(32'h0, rate_for_error(32'h0, cap_err[i]));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
    logic [31:0] hdg, rate;
    program_regs($urandom, rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                 $urandom_range(1) ? {1'($urandom), 31'($urandom_range(0, 1 << 22))}
                                   : $urandom);
    src_idle_pct = src_pct;
    stall_pct    = sink_pct;
    repeat (n) begin
      gen_random_item(hdg, rate);
      push_sample(hdg, rate);
    end
    wait_for_results();
  endtask

  // drive the integral into its 40-bit ceiling, then back off
  task automatic test_integral_windup();
    logic [31:0] hdg;
    program_regs('0, '0, '0, '0, '0, 32'h0000_0001, 32'h7FFF_FFFF);
    src_idle_pct = 0;
    stall_pct    = 29;
    repeat (275) begin
      hdg = $urandom;
      push_sample(hdg, rate_for_error(hdg, 64'sd2147483646 - $urandom_range(0, 3)));
    end
    repeat (10) begin
      hdg = $urandom;
      push_sample(hdg, rate_for_error(hdg, -64'sd2147483646));
    end
    wait_for_results();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    logic [31:0] hdg, rate;
    program_regs($urandom, rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                 32'($urandom_range(0, 1 << 24)));
    src_idle_pct = 0;
    stall_pct    = 0;
    -> hold_kick;
    repeat (30) begin
      gen_random_item(hdg, rate);
      push_sample(hdg, rate);
    end
    wait_for_results();
  endtask

  initial begin
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic(0, 0, 60);
    test_random_traffic(76, 0, 60);
    test_random_traffic(0, 76, 60);
    test_random_traffic(29, 29, 60);
    test_integral_windup();
    test_backpressure();
    wait_for_results();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: cascade_yaw_pid_thruster_mix_core.f
design/cyptm_pkg.sv
design/cyptm_mul.sv
design/cascade_yaw_pid_thruster_mix_core.sv
verif/tb_top.sv
